// File: rtl/core/fde_pkg.sv
package fde_pkg;

   localparam int MAX_DEN     = 64;
   localparam int MAX_RESULTS = 63;
   localparam int DIGIT_BASE  = 10;

   localparam int IN_W    = 7;
   localparam int DIGIT_W = 4;
   localparam int POS_W   = 6;

   // remainders are always below the denominator
   localparam int REM_W = $clog2(MAX_DEN);
   // remainder times ten, also wide enough for the denominator shifted by three
   localparam int DIV_W = REM_W + 4;
   // one restoring step per quotient bit of the digit
   localparam int DIV_STEPS = DIGIT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [IN_W-1:0] numerator;
      logic [IN_W-1:0] denominator;
   } req_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               last;
      logic               repeating;
      logic [POS_W-1:0]   cycle_start;
      logic [POS_W-1:0]   cycle_end;
      logic               bad_input;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic start_run;
      logic emit_bad;
      logic step;
      logic div_step;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic out_free;
      logic last;
   } status_type;

endpackage

// File: rtl/core/fde_ram.sv
module fde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/fde_datapath.sv
module fde_datapath (
   input  logic               clock,
   input  logic               reset,
   input  fde_pkg::cmd_type   cmd,
   output fde_pkg::status_type status,
   input  fde_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fde_pkg::rsp_type   rsp_data
);

   import fde_pkg::*;

   logic [IN_W-1:0]    num_ff, num_in;
   logic [IN_W-1:0]    den_ff, den_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [POS_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]   part_ff, part_in;
   logic [DIV_W-1:0]   dsh_ff, dsh_in;
   logic [DIGIT_W-1:0] quo_ff, quo_in;
   logic [MAX_DEN-1:0] seen_ff, seen_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;

   logic [REM_W-1:0]   new_rem;
   logic [POS_W-1:0]   next_pos;
   logic [POS_W-1:0]   first_pos;
   logic               rem_zero;
   logic               hit;
   logic               at_limit;

   assign new_rem  = part_ff[REM_W-1:0];
   assign next_pos = cnt_ff + POS_W'(1);
   assign rem_zero = (new_rem == '0);
   assign hit      = !rem_zero && seen_ff[new_rem];
   assign at_limit = (cnt_ff == POS_W'(MAX_RESULTS));

   // position of first use for each remainder
   fde_ram #(
      .WIDTH (POS_W),
      .DEPTH (MAX_DEN)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (cmd.step),
      .wr_addr (rem_ff),
      .wr_data (next_pos),
      .rd_addr (new_rem),
      .rd_data (first_pos)
   );

   always_comb begin
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      part_in      = part_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      seen_in      = seen_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (cmd.capture) begin
         num_in = req_data.numerator;
         den_in = req_data.denominator;
      end

      if (cmd.start_run) begin
         rem_in  = num_ff[REM_W-1:0];
         cnt_in  = '0;
         seen_in = '0;
      end

      if (cmd.step) begin
         cnt_in          = next_pos;
         seen_in[rem_ff] = 1'b1;
         // remainder times ten as two shifts
         part_in = DIV_W'({rem_ff, 3'b000}) + DIV_W'({rem_ff, 1'b0});
         dsh_in  = DIV_W'({den_ff, 3'b000});
         quo_in  = '0;
      end

      if (cmd.div_step) begin
         if (part_ff >= dsh_ff) begin
            part_in = part_ff - dsh_ff;
            quo_in  = {quo_ff[DIGIT_W-2:0], 1'b1};
         end else begin
            quo_in  = {quo_ff[DIGIT_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
      end

      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.emit_bad) begin
         out_valid_in       = 1'b1;
         out_in             = '0;
         out_in.last        = 1'b1;
         out_in.bad_input   = 1'b1;
      end

      if (cmd.emit_digit) begin
         rem_in             = new_rem;
         out_valid_in       = 1'b1;
         out_in.digit       = quo_ff;
         out_in.last        = rem_zero || hit || at_limit;
         out_in.repeating   = hit;
         out_in.cycle_start = hit ? first_pos : '0;
         out_in.cycle_end   = hit ? cnt_ff : '0;
         out_in.bad_input   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         seen_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         seen_ff      <= seen_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      part_ff <= part_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      out_ff  <= out_in;
   end

   assign status.bad      = (num_ff == '0) || (num_ff >= den_ff) ||
                            ({1'b0, den_ff} > (IN_W+1)'(MAX_DEN));
   assign status.out_free = !out_valid_ff || rsp_ready;
   assign status.last     = rem_zero || hit || at_limit;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: rtl/core/fde_ctrl.sv
module fde_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fde_pkg::status_type status,
   output fde_pkg::cmd_type    cmd
);

   import fde_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STEP,
      ST_DIV,
      ST_LOOK,
      ST_DECIDE
   } state_type;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.bad) begin
               if (status.out_free) begin
                  cmd.emit_bad = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.start_run = 1'b1;
               state_in      = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step   = 1'b1;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_LOOK;
            end else begin
               div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            end
         end
         ST_LOOK: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               state_in       = status.last ? ST_IDLE : ST_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

// File: rtl/core/fraction_decimal_expander_unit.sv
// Fraction decimal expander.
// Input channel (req_*): one transfer carries numerator and denominator of a
// proper fraction. Result channel (rsp_*): one transfer per decimal digit by
// long division; the last one of a fraction has last set and, for a
// recurring decimal, the first and last digit positions of the cycle.
// A fraction outside 0 < numerator < denominator <= MAX_DEN gives a single
// result with bad_input and last set and no digits.
// An out-of-range fraction is caught by the range check, and its result is
// loaded into the output register once that register is free. A valid
// fraction passes the range check, then each digit goes through a step that
// records the remainder's position in the table RAM, the restoring division
// of remainder times ten (one quotient bit per step), the registered table
// read, and a decide step that loads the output register.
// A fraction gives at most 63 digits, and the next input is taken only once
// the controller is back in idle after the last result is loaded.
// The position table is a 64 x 6 RAM; per-remainder seen flags in flops are
// cleared all at once at the start of each fraction, so there is no sweep.
// Reset empties the output register and returns the controller to idle.
// When the receiver stalls, the pending result holds in the output register
// and the next digit waits in its decide step until the register frees up.
module fraction_decimal_expander_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fde_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fde_pkg::rsp_type rsp_data
);

   import fde_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing: setup, per-digit step, division, table lookup, decide
   fde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // operands, divider, table RAM and output register
   fde_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/core/fde_checker.sv
module fde_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fde_pkg::rsp_type rsp_data
);

   import fde_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.digit <= DIGIT_W'(DIGIT_BASE - 1))
      else $error("digit out of range");

   a_bad_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_input |->
         rsp_data.last && !rsp_data.repeating && rsp_data.digit == '0)
      else $error("malformed error result");

   a_mid_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |->
         !rsp_data.repeating && rsp_data.cycle_start == '0 &&
         rsp_data.cycle_end == '0 && !rsp_data.bad_input)
      else $error("non-final result carries cycle info");

   a_cycle_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.repeating |->
         rsp_data.last && rsp_data.cycle_start != '0 &&
         rsp_data.cycle_start <= rsp_data.cycle_end)
      else $error("cycle positions inconsistent");

endmodule

bind fraction_decimal_expander_unit fde_checker u_fde_checker (.*);
